>>> sv/http_chunked_response_deframer_defines.svh
// Assertion macros for the chunked response deframer checker.
`ifndef HTTP_CHUNKED_RESPONSE_DEFRAMER_DEFINES_SVH
`define HTTP_CHUNKED_RESPONSE_DEFRAMER_DEFINES_SVH

// Same-cycle implication, reset-gated.
`define HCRD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset-gated.
`define HCRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/hcrd_pkg.sv
// ----------------------------------------------------------------------------
// hcrd_pkg
// Types, codes and character constants of the chunked response deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcrd_pkg;

	localparam int KIND_W   = 2;
	localparam int STATUS_W = 10;
	localparam int BYTE_W   = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_DATA  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_PRE    = 2'd0,
		ST_DIGITS = 2'd1,
		ST_POST   = 2'd2
	} status_phase_t;

	typedef enum logic [2:0] {
		CH_SIZE    = 3'd0,
		CH_SIZE_LF = 3'd1,
		CH_DATA    = 3'd2,
		CH_TRAIL1  = 3'd3,
		CH_TRAIL2  = 3'd4
	} chunk_phase_t;

	localparam logic [7:0]  CHR_CR    = 8'h0d;
	localparam logic [7:0]  CHR_LF    = 8'h0a;
	localparam logic [7:0]  CHR_SEMI  = 8'h3b;
	localparam logic [7:0]  CHR_SPACE = 8'h20;
	localparam logic [31:0] HDR_END   = 32'h0d0a0d0a;

	localparam logic [STATUS_W-1:0] STATUS_MAX   = 10'd999;
	localparam logic [STATUS_W-1:0] STATUS_RESET = 10'd200;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.valid = 1'b1;
		h.value = c[3:0];
		if (is_digit(c)) begin
			h.value = c[3:0];
		end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
			h.value = c[3:0] + 4'd9;
		end else begin
			h.valid = 1'b0;
			h.value = 4'd0;
		end
		hex_decode = h;
	endfunction

endpackage

`default_nettype wire

>>> sv/http_chunked_response_deframer.sv
// ----------------------------------------------------------------------------
// http_chunked_response_deframer
// Status check, header skip and chunked body decode of an HTTP response.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per response byte: tuser is the command
//   (0 = byte, 1 = restart), tdata is the byte. Restart clears the parser.
//   m_axis carries at most one result per request: tuser is the kind
//   (body byte, complete, bad status), tdata holds body byte and status code.
//   cfg writes expected_status; write it only while the block is idle.
// Timing:
//   One request per cycle while s_axis_tready is high. Each result is
//   registered on m_axis; all parser state updates at the accepting edge.
// Stall:
//   An output register plus a one-entry skid buffer sit on m_axis. Input
//   keeps flowing while one result waits; s_axis_tready drops only when the
//   skid entry is occupied too.
// Reset:
//   arst_n clears the parser, empties the output and sets expected_status
//   to 200.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_response_deframer #(
	parameter int SIZE_WIDTH      = 32,
	parameter int STATUS_LINE_MAX = 40
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic [0:0]  s_axis_tuser,   // [0] cmd
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [7:0] body_byte, [17:8] resp_code, [23:18] zero
	output logic [1:0]       m_axis_tuser,   // [1:0] kind
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [9:0]  cfg_data        // [9:0] expected_status
);

	localparam int LEN_W = $clog2(STATUS_LINE_MAX);
	localparam logic [LEN_W:0] LINE_MAX = (LEN_W+1)'(STATUS_LINE_MAX);

	logic                          finished_q, finished_d;
	logic                          status_done_q, status_done_d;
	hcrd_pkg::status_phase_t       status_phase_q, status_phase_d;
	logic [LEN_W-1:0]              status_len_q, status_len_d;
	logic [hcrd_pkg::STATUS_W-1:0] status_value_q, status_value_d;
	logic                          headers_done_q, headers_done_d;
	logic [31:0]                   last_four_q, last_four_d;
	hcrd_pkg::chunk_phase_t        chunk_phase_q, chunk_phase_d;
	logic [SIZE_WIDTH-1:0]         chunk_length_q, chunk_length_d;
	logic [SIZE_WIDTH-1:0]         chunk_count_q, chunk_count_d;
	logic                          in_ext_q, in_ext_d;
	logic [hcrd_pkg::STATUS_W-1:0] expected_q;

	logic        in_fire;
	logic [7:0]  c;
	logic        cmd;
	logic [LEN_W:0] len_inc;
	logic [13:0] st_mul;
	hcrd_pkg::hex_t hx;
	logic [SIZE_WIDTH-1:0] count_inc;
	logic        active;

	logic            res_valid;
	hcrd_pkg::kind_t res_kind;
	logic [7:0]      res_byte;
	logic [23:0]     res_data;

	logic        out_v_q;
	logic [23:0] out_data_q;
	logic [1:0]  out_kind_q;
	logic        skid_v_q;
	logic [23:0] skid_data_q;
	logic [1:0]  skid_kind_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !skid_v_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign c             = s_axis_tdata;
	assign cmd           = s_axis_tuser[0];
	assign active        = in_fire && !cmd && !finished_q;

	assign len_inc   = {1'b0, status_len_q} + {{LEN_W{1'b0}}, 1'b1};
	assign st_mul    = {4'd0, status_value_q} * 14'd10 + {10'd0, c[3:0]};
	assign hx        = hcrd_pkg::hex_decode(c);
	assign count_inc = chunk_count_q + {{(SIZE_WIDTH-1){1'b0}}, 1'b1};

	// next parser state
	always_comb begin
		finished_d     = finished_q;
		status_done_d  = status_done_q;
		status_phase_d = status_phase_q;
		status_len_d   = status_len_q;
		status_value_d = status_value_q;
		headers_done_d = headers_done_q;
		last_four_d    = last_four_q;
		chunk_phase_d  = chunk_phase_q;
		chunk_length_d = chunk_length_q;
		chunk_count_d  = chunk_count_q;
		in_ext_d       = in_ext_q;
		if (in_fire && cmd) begin
			finished_d     = 1'b0;
			status_done_d  = 1'b0;
			status_phase_d = hcrd_pkg::ST_PRE;
			status_len_d   = '0;
			status_value_d = '0;
			headers_done_d = 1'b0;
			last_four_d    = '0;
			chunk_phase_d  = hcrd_pkg::CH_SIZE;
			chunk_length_d = '0;
			chunk_count_d  = '0;
			in_ext_d       = 1'b0;
		end else if (active && !headers_done_q) begin
			if (!status_done_q) begin
				if (c == hcrd_pkg::CHR_CR) begin
					status_done_d = 1'b1;
					if (status_value_q != expected_q) begin
						finished_d = 1'b1;
					end
				end else if (len_inc < LINE_MAX) begin
					status_len_d = len_inc[LEN_W-1:0];
					unique case (status_phase_q)
						hcrd_pkg::ST_PRE: begin
							if (c == hcrd_pkg::CHR_SPACE) begin
								status_phase_d = hcrd_pkg::ST_DIGITS;
							end
						end
						hcrd_pkg::ST_DIGITS: begin
							if (hcrd_pkg::is_digit(c)) begin
								status_value_d = (st_mul > 14'(hcrd_pkg::STATUS_MAX)) ?
									hcrd_pkg::STATUS_MAX : st_mul[9:0];
							end else begin
								status_phase_d = hcrd_pkg::ST_POST;
							end
						end
						default: begin
						end
					endcase
				end
			end
			last_four_d = {last_four_q[23:0], c};
			if ({last_four_q[23:0], c} == hcrd_pkg::HDR_END) begin
				headers_done_d = 1'b1;
			end
		end else if (active) begin
			unique case (chunk_phase_q)
				hcrd_pkg::CH_SIZE: begin
					if (hx.valid && !in_ext_q) begin
						chunk_length_d = {chunk_length_q[SIZE_WIDTH-5:0], hx.value};
					end else if (c == hcrd_pkg::CHR_SEMI) begin
						in_ext_d = 1'b1;
					end else if (c == hcrd_pkg::CHR_CR) begin
						chunk_phase_d = hcrd_pkg::CH_SIZE_LF;
					end
				end
				hcrd_pkg::CH_SIZE_LF: begin
					if (c == hcrd_pkg::CHR_LF) begin
						if (chunk_length_q == '0) begin
							finished_d = 1'b1;
						end else begin
							chunk_count_d = '0;
							chunk_phase_d = hcrd_pkg::CH_DATA;
						end
					end
				end
				hcrd_pkg::CH_DATA: begin
					chunk_count_d = count_inc;
					if (count_inc >= chunk_length_q) begin
						chunk_phase_d = hcrd_pkg::CH_TRAIL1;
					end
				end
				hcrd_pkg::CH_TRAIL1: begin
					chunk_phase_d = hcrd_pkg::CH_TRAIL2;
				end
				default: begin
					chunk_length_d = '0;
					chunk_count_d  = '0;
					in_ext_d       = 1'b0;
					chunk_phase_d  = hcrd_pkg::CH_SIZE;
				end
			endcase
		end
	end

	// result of the accepted request
	always_comb begin
		res_valid = 1'b0;
		res_kind  = hcrd_pkg::KIND_DATA;
		res_byte  = 8'd0;
		if (active && !headers_done_q) begin
			if (!status_done_q && (c == hcrd_pkg::CHR_CR) && (status_value_q != expected_q)) begin
				res_valid = 1'b1;
				res_kind  = hcrd_pkg::KIND_ERROR;
			end
		end else if (active) begin
			if ((chunk_phase_q == hcrd_pkg::CH_SIZE_LF) && (c == hcrd_pkg::CHR_LF) &&
				(chunk_length_q == '0)) begin
				res_valid = 1'b1;
				res_kind  = hcrd_pkg::KIND_DONE;
			end else if (chunk_phase_q == hcrd_pkg::CH_DATA) begin
				res_valid = 1'b1;
				res_kind  = hcrd_pkg::KIND_DATA;
				res_byte  = c;
			end
		end
	end

	assign res_data = {6'd0, status_value_q, res_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finished_q     <= 1'b0;
			status_done_q  <= 1'b0;
			status_phase_q <= hcrd_pkg::ST_PRE;
			status_len_q   <= '0;
			status_value_q <= '0;
			headers_done_q <= 1'b0;
			last_four_q    <= '0;
			chunk_phase_q  <= hcrd_pkg::CH_SIZE;
			chunk_length_q <= '0;
			chunk_count_q  <= '0;
			in_ext_q       <= 1'b0;
			expected_q     <= hcrd_pkg::STATUS_RESET;
		end else begin
			finished_q     <= finished_d;
			status_done_q  <= status_done_d;
			status_phase_q <= status_phase_d;
			status_len_q   <= status_len_d;
			status_value_q <= status_value_d;
			headers_done_q <= headers_done_d;
			last_four_q    <= last_four_d;
			chunk_phase_q  <= chunk_phase_d;
			chunk_length_q <= chunk_length_d;
			chunk_count_q  <= chunk_count_d;
			in_ext_q       <= in_ext_d;
			if (cfg_valid && cfg_ready) begin
				expected_q <= cfg_data;
			end
		end
	end

	// output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || m_axis_tready) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= res_valid;
				end
			end else if (res_valid) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			if (skid_v_q) begin
				out_data_q <= skid_data_q;
				out_kind_q <= skid_kind_q;
			end else if (res_valid) begin
				out_data_q <= res_data;
				out_kind_q <= res_kind;
			end
		end else if (res_valid) begin
			skid_data_q <= res_data;
			skid_kind_q <= res_kind;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;

endmodule

`default_nettype wire

>>> sv/hcrd_checker.sv
// ----------------------------------------------------------------------------
// hcrd_checker
// Port-level checks on the result stream of the chunked response deframer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_chunked_response_deframer_defines.svh"

module hcrd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);

	`HCRD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
	`HCRD_ASSERT_NOW(a_kind_legal, m_axis_tvalid, m_axis_tuser != 2'd3, "illegal result kind")
	`HCRD_ASSERT_NOW(a_byte_zero, m_axis_tvalid && (m_axis_tuser != hcrd_pkg::KIND_DATA), m_axis_tdata[7:0] == 8'd0, "body byte set on non-data result")
	`HCRD_ASSERT_NOW(a_status_range, m_axis_tvalid, (m_axis_tdata[17:8] <= hcrd_pkg::STATUS_MAX) && (m_axis_tdata[23:18] == 6'd0), "status code out of range")

endmodule

bind http_chunked_response_deframer hcrd_checker u_hcrd_checker (.*);

`default_nettype wire
